// File: hdl/lru_pr_pkg.sv
// lru_pr_pkg: shared types for the lru page replacement block
// no dependencies; used by lru_pr_cell and lru_page_replacement
package lru_pr_pkg;

    // control part of the search token that walks the cell chain
    typedef struct packed {
        logic valid;
        logic hit_found;
        logic empty_found;
    } tok_flags_t;

    // control part of the update broadcast to every cell
    typedef struct packed {
        logic apply;
        logic set_page;
        logic set_valid;
        logic age_all;
    } upd_ctl_t;

    localparam int CFG_W = 4;

endpackage

// File: hdl/lru_pr_cell.sv
// lru_pr_cell: one page frame (page, valid, recency rank) plus one stage of the search token
// depends on lru_pr_pkg
module lru_pr_cell #(
    parameter int PAGE_W = 16,
    parameter int IDX_W  = 3
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [IDX_W-1:0]       cell_index,
    input  logic                   active,
    input  lru_pr_pkg::tok_flags_t in_flags,
    input  logic [PAGE_W-1:0]      in_page,
    input  logic [IDX_W-1:0]       in_hit_idx,
    input  logic [IDX_W-1:0]       in_hit_rank,
    input  logic [IDX_W-1:0]       in_empty_idx,
    input  logic [IDX_W-1:0]       in_best_rank,
    input  logic [IDX_W-1:0]       in_best_idx,
    input  logic [PAGE_W-1:0]      in_best_page,
    output lru_pr_pkg::tok_flags_t out_flags,
    output logic [PAGE_W-1:0]      out_page,
    output logic [IDX_W-1:0]       out_hit_idx,
    output logic [IDX_W-1:0]       out_hit_rank,
    output logic [IDX_W-1:0]       out_empty_idx,
    output logic [IDX_W-1:0]       out_best_rank,
    output logic [IDX_W-1:0]       out_best_idx,
    output logic [PAGE_W-1:0]      out_best_page,
    input  lru_pr_pkg::upd_ctl_t   upd,
    input  logic [IDX_W-1:0]       upd_idx,
    input  logic [IDX_W-1:0]       upd_rank,
    input  logic [PAGE_W-1:0]      upd_page
);
    import lru_pr_pkg::*;

    logic [PAGE_W-1:0] page_reg;
    logic [PAGE_W-1:0] page_next;
    logic              valid_reg;
    logic              valid_next;
    logic [IDX_W-1:0]  rank_reg;
    logic [IDX_W-1:0]  rank_next;

    tok_flags_t        flags_reg;
    tok_flags_t        flags_next;
    logic [PAGE_W-1:0] tpage_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic [IDX_W-1:0]  hit_idx_next;
    logic [IDX_W-1:0]  hit_rank_reg;
    logic [IDX_W-1:0]  hit_rank_next;
    logic [IDX_W-1:0]  empty_idx_reg;
    logic [IDX_W-1:0]  empty_idx_next;
    logic [IDX_W-1:0]  best_rank_reg;
    logic [IDX_W-1:0]  best_rank_next;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [IDX_W-1:0]  best_idx_next;
    logic [PAGE_W-1:0] best_page_reg;
    logic [PAGE_W-1:0] best_page_next;

    logic              is_hit;
    logic              is_empty;
    logic              is_best;

    // local lookup against the passing token
    always_comb
    begin
        is_hit   = active && valid_reg && (page_reg == in_page) && !in_flags.hit_found;
        is_empty = active && !valid_reg && !in_flags.empty_found;
        is_best  = active && ((cell_index == '0) || (rank_reg > in_best_rank));

        flags_next.valid       = in_flags.valid;
        flags_next.hit_found   = in_flags.hit_found || is_hit;
        flags_next.empty_found = in_flags.empty_found || is_empty;
        hit_idx_next   = is_hit ? cell_index : in_hit_idx;
        hit_rank_next  = is_hit ? rank_reg : in_hit_rank;
        empty_idx_next = is_empty ? cell_index : in_empty_idx;
        best_rank_next = is_best ? rank_reg : in_best_rank;
        best_idx_next  = is_best ? cell_index : in_best_idx;
        best_page_next = is_best ? page_reg : in_best_page;
    end

    // frame state update from the broadcast decision
    always_comb
    begin
        page_next  = page_reg;
        valid_next = valid_reg;
        rank_next  = rank_reg;
        if (upd.apply)
        begin
            if (cell_index == upd_idx)
            begin
                rank_next = '0;
                if (upd.set_page)
                    page_next = upd_page;
                if (upd.set_valid)
                    valid_next = 1'b1;
            end
            else if (valid_reg && (upd.age_all || (rank_reg < upd_rank)))
            begin
                rank_next = rank_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
            flags_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg      <= page_next;
        tpage_reg     <= in_page;
        hit_idx_reg   <= hit_idx_next;
        hit_rank_reg  <= hit_rank_next;
        empty_idx_reg <= empty_idx_next;
        best_rank_reg <= best_rank_next;
        best_idx_reg  <= best_idx_next;
        best_page_reg <= best_page_next;
    end

    assign out_flags     = flags_reg;
    assign out_page      = tpage_reg;
    assign out_hit_idx   = hit_idx_reg;
    assign out_hit_rank  = hit_rank_reg;
    assign out_empty_idx = empty_idx_reg;
    assign out_best_rank = best_rank_reg;
    assign out_best_idx  = best_idx_reg;
    assign out_best_page = best_page_reg;

endmodule

// File: hdl/lru_page_replacement.sv
// lru_page_replacement: fully associative lru page replacement over a chain of frame cells
// depends on lru_pr_pkg and lru_pr_cell
//
// channel   direction  handshake                    payload
// request   in         start, busy                  page_number
// result    out        done (one-cycle strobe)      hit, frame_index, evicted_valid,
//                                                   evicted_page, fault_total
// config    in         cfg_we                       cfg_wdata (frames in use)
//
// a reference sends the search token through the frame cells, one frame
// cell per cycle, then the update is applied and the result registered
// busy is high from the accepting edge until the result edge
// reset clears all frames to empty, the fault count to zero and frames in use to 8
// the receiver cannot stall; done is high for exactly one cycle per transaction
module lru_page_replacement #(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [15:0]                  page_number,
    input  logic                         cfg_we,
    input  logic [lru_pr_pkg::CFG_W-1:0] cfg_wdata,
    output logic                         done,
    output logic                         hit,
    output logic [2:0]                   frame_index,
    output logic                         evicted_valid,
    output logic [15:0]                  evicted_page,
    output logic [31:0]                  fault_total
);
    import lru_pr_pkg::*;

    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    logic [CFG_W-1:0]  frames_reg;
    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              hit_reg;
    logic [2:0]        frame_reg;
    logic              evict_reg;
    logic [15:0]       evict_page_reg;
    logic [31:0]       fault_reg;
    logic [31:0]       fault_next;

    logic [7:0]            frames_ext;
    logic [7:0]            eff_frames;
    logic [MAX_FRAMES-1:0] active;
    logic [MAX_FRAMES-1:0] tok_valid;

    tok_flags_t        t_flags     [MAX_FRAMES+1];
    logic [PAGE_BITS-1:0] t_page   [MAX_FRAMES+1];
    logic [IDX_W-1:0]  t_hit_idx   [MAX_FRAMES+1];
    logic [IDX_W-1:0]  t_hit_rank  [MAX_FRAMES+1];
    logic [IDX_W-1:0]  t_empty_idx [MAX_FRAMES+1];
    logic [IDX_W-1:0]  t_best_rank [MAX_FRAMES+1];
    logic [IDX_W-1:0]  t_best_idx  [MAX_FRAMES+1];
    logic [PAGE_BITS-1:0] t_best_page [MAX_FRAMES+1];

    tok_flags_t        last;
    upd_ctl_t          upd;
    logic [IDX_W-1:0]  upd_idx;
    logic [IDX_W-1:0]  upd_rank;
    logic              is_fill;

    // clamp frames in use to 1..MAX_FRAMES
    always_comb
    begin
        frames_ext = {{(8-CFG_W){1'b0}}, frames_reg};
        priority if (frames_ext == 8'd0)
            eff_frames = 8'd1;
        else if (frames_ext > 8'(MAX_FRAMES))
            eff_frames = 8'(MAX_FRAMES);
        else
            eff_frames = frames_ext;
    end

    // token launch
    always_comb
    begin
        t_flags[0].valid       = start && !busy_reg;
        t_flags[0].hit_found   = 1'b0;
        t_flags[0].empty_found = 1'b0;
        t_page[0]      = PAGE_BITS'(page_number);
        t_hit_idx[0]   = '0;
        t_hit_rank[0]  = '0;
        t_empty_idx[0] = '0;
        t_best_rank[0] = '0;
        t_best_idx[0]  = '0;
        t_best_page[0] = '0;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_FRAMES; gi++)
        begin : g_cell
            assign active[gi]    = (8'(gi) < eff_frames);
            assign tok_valid[gi] = t_flags[gi+1].valid;

            lru_pr_cell #(
                .PAGE_W (PAGE_BITS),
                .IDX_W  (IDX_W)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .cell_index    (IDX_W'(gi)),
                .active        (active[gi]),
                .in_flags      (t_flags[gi]),
                .in_page       (t_page[gi]),
                .in_hit_idx    (t_hit_idx[gi]),
                .in_hit_rank   (t_hit_rank[gi]),
                .in_empty_idx  (t_empty_idx[gi]),
                .in_best_rank  (t_best_rank[gi]),
                .in_best_idx   (t_best_idx[gi]),
                .in_best_page  (t_best_page[gi]),
                .out_flags     (t_flags[gi+1]),
                .out_page      (t_page[gi+1]),
                .out_hit_idx   (t_hit_idx[gi+1]),
                .out_hit_rank  (t_hit_rank[gi+1]),
                .out_empty_idx (t_empty_idx[gi+1]),
                .out_best_rank (t_best_rank[gi+1]),
                .out_best_idx  (t_best_idx[gi+1]),
                .out_best_page (t_best_page[gi+1]),
                .upd           (upd),
                .upd_idx       (upd_idx),
                .upd_rank      (upd_rank),
                .upd_page      (t_page[MAX_FRAMES])
            );
        end
    endgenerate

    // decision from the token leaving the last cell
    always_comb
    begin
        last    = t_flags[MAX_FRAMES];
        is_fill = !last.hit_found && last.empty_found;

        upd.apply     = last.valid;
        upd.set_page  = !last.hit_found;
        upd.set_valid = is_fill;
        upd.age_all   = is_fill;

        priority if (last.hit_found)
        begin
            upd_idx  = t_hit_idx[MAX_FRAMES];
            upd_rank = t_hit_rank[MAX_FRAMES];
        end
        else if (last.empty_found)
        begin
            upd_idx  = t_empty_idx[MAX_FRAMES];
            upd_rank = '0;
        end
        else
        begin
            upd_idx  = t_best_idx[MAX_FRAMES];
            upd_rank = t_best_rank[MAX_FRAMES];
        end

        fault_next = fault_reg;
        if (last.valid && !last.hit_found && (fault_reg != '1))
            fault_next = fault_reg + 32'd1;

        busy_next = busy_reg;
        if (t_flags[0].valid)
            busy_next = 1'b1;
        else if (last.valid)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg <= CFG_W'(8);
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            fault_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
                frames_reg <= cfg_wdata;
            busy_reg  <= busy_next;
            done_reg  <= last.valid;
            fault_reg <= fault_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (last.valid)
        begin
            hit_reg        <= last.hit_found;
            frame_reg      <= 3'(upd_idx);
            evict_reg      <= !last.hit_found && !last.empty_found;
            evict_page_reg <= (!last.hit_found && !last.empty_found)
                              ? 16'(t_best_page[MAX_FRAMES]) : 16'd0;
        end
    end

    assign busy          = busy_reg;
    assign done          = done_reg;
    assign hit           = hit_reg;
    assign frame_index   = frame_reg;
    assign evicted_valid = evict_reg;
    assign evicted_page  = evict_page_reg;
    assign fault_total   = fault_reg;

    // one token in the chain at most
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_valid))
        else $error("more than one token in the cell chain");

    // no token in flight while idle
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (tok_valid == '0))
        else $error("token in the chain while idle");

    // the result closes the transaction
    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $fell(busy_reg))
        else $error("result without end of transaction");

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && hit_reg) |-> !evict_reg)
        else $error("eviction on a hit");

    // a miss leaves a nonzero fault count
    a_miss_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !hit_reg) |-> (fault_reg != '0))
        else $error("miss without fault count");

endmodule
